/* hdl/csd_pkg.sv */
// Shared types and constants of the circular-scan disk scheduler.
`default_nettype none
package csd_pkg;

   localparam int CYL_W    = 16;
   localparam int TRAVEL_W = 18;

   // configuration register indexes
   localparam logic [1:0] REG_TOP_CYLINDER = 2'd0;
   localparam logic [1:0] REG_START_HEAD   = 2'd1;
   localparam logic [1:0] REG_SWEEP_UP     = 2'd2;

   // reset values of the configuration registers
   localparam logic [CYL_W-1:0] RESET_TOP  = 16'd199;
   localparam logic [CYL_W-1:0] RESET_HEAD = 16'd50;

   // command codes on the request channel
   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_RUN = 1'b1;

   // one command handed from the front end to the scheduler engine
   typedef struct packed {
      logic             run;
      logic [CYL_W-1:0] cyl;
      logic             ovf;
   } op_type;

   // configuration seen by the engine
   typedef struct packed {
      logic [CYL_W-1:0] top;
      logic [CYL_W-1:0] head;
      logic             up;
   } cfg_type;

   // engine states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS1,
      ST_TOPFIX,
      ST_JUMP,
      ST_ZERO,
      ST_PASS2,
      ST_FLUSH
   } state_type;

endpackage
`default_nettype wire

/* hdl/csd_front.sv */
// Front end: takes request transfers, tracks fill count and drops, queues commands.
`default_nettype none
module csd_front #(
   parameter int MAX_PENDING = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   input  wire                 in_cmd,
   input  wire [15:0]          in_cyl,
   output logic                in_ready,
   output csd_pkg::op_type     op_out,
   output logic                op_push,
   input  wire                 op_room
);
   import csd_pkg::*;

   localparam int CNT_W = $clog2(MAX_PENDING + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             take;
   logic             full;

   assign in_ready = op_room;
   assign take     = in_valid & op_room;
   assign full     = (count_ff == CNT_W'(MAX_PENDING));

   // classify the transfer: store, drop or run
   always_comb begin
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      op_push    = 1'b0;
      op_out.run = in_cmd;
      op_out.cyl = in_cyl;
      op_out.ovf = ovf_ff;
      if (take) begin
         if (in_cmd == CMD_RUN) begin
            op_push  = 1'b1;
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (full) begin
            ovf_in = 1'b1;
         end else begin
            op_push  = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PENDING)) else $error("fill count above capacity");
   a_drop_flags: assert property (@(posedge clock) disable iff (reset)
      take && in_cmd == CMD_ADD && full |=> ovf_ff) else $error("drop not flagged");
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      take && in_cmd == CMD_RUN |=> count_ff == '0 && !ovf_ff)
      else $error("run did not clear store state");

endmodule
`default_nettype wire

/* hdl/csd_queue.sv */
// Two-entry command queue between front end and engine.
`default_nettype none
module csd_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  csd_pkg::op_type  push_op,
   output logic             room,
   output logic             avail,
   output csd_pkg::op_type  pop_op,
   input  wire              pop
);
   import csd_pkg::*;

   op_type     slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;

   assign room   = (fill_ff != 2'd2);
   assign avail  = (fill_ff != 2'd0);
   assign pop_op = slot_ff[rptr_ff];

   // pointer and fill update
   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_op;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> room || pop) else $error("queue overrun");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> avail) else $error("queue underrun");
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop && fill_ff == 2'd0 |=> fill_ff == 2'd1) else $error("fill lost");

endmodule
`default_nettype wire

/* hdl/csd_engine.sv */
// Scheduler engine: sorted request ring, C-SCAN walk, travel sum, result register.
`default_nettype none
module csd_engine #(
   parameter int MAX_PENDING = 32
) (
   input  wire              clock,
   input  wire              reset,
   input  csd_pkg::cfg_type cfg,
   input  wire              op_avail,
   input  csd_pkg::op_type  op_in,
   output logic             op_pop,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output logic [15:0]      rsp_cyl,
   output logic [17:0]      rsp_travel,
   output logic             rsp_ovf,
   output logic             rsp_last
);
   import csd_pkg::*;

   localparam int N    = MAX_PENDING;
   localparam int CW   = (N > 1) ? $clog2(N) : 1;

   // sorted ring
   logic [CYL_W-1:0] cell_ff [N];
   logic [CYL_W-1:0] cell_in [N];
   logic [N-1:0]     valid_ff, valid_in;
   logic [N-1:0]     gt;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CYL_W-1:0]   pos_ff, pos_in;
   logic [TRAVEL_W-1:0] acc_ff, acc_in;
   logic               top_done_ff, top_done_in;
   logic               ovf_ff, ovf_in;
   logic               up_ff, up_in;
   logic               hold_valid_ff, hold_valid_in;
   logic [CYL_W-1:0]   hold_cyl_ff, hold_cyl_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CYL_W-1:0]   rsp_cyl_ff, rsp_cyl_in;
   logic [TRAVEL_W-1:0] rsp_travel_ff, rsp_travel_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   // step decisions
   logic               go;
   logic               in_pass;
   logic [CYL_W-1:0]   cur;
   logic               cur_valid;
   logic               want_high;
   logic               merge_top;
   logic               member;
   logic               pass_end;
   logic               produce;
   logic [CYL_W-1:0]   prod_val;
   logic               rotate;
   logic [CYL_W-1:0]   cost;
   logic [TRAVEL_W:0]  sum;
   logic [TRAVEL_W:0]  jsum;

   assign go        = !rsp_valid_ff | rsp_ready;
   assign in_pass   = (state_ff == ST_PASS1) || (state_ff == ST_PASS2);
   assign cur       = up_ff ? cell_ff[0] : cell_ff[N-1];
   assign cur_valid = up_ff ? valid_ff[0] : valid_ff[N-1];
   assign want_high = ((state_ff == ST_PASS1) == up_ff);
   assign merge_top = want_high & !top_done_ff & cur_valid &
                      (up_ff ? (cfg.top < cur) : (cfg.top > cur));
   assign member    = cur_valid & ((cur >= cfg.head) == want_high);
   assign pass_end  = in_pass & go & !merge_top & (cnt_ff == CW'(N - 1));
   assign op_pop    = (state_ff == ST_IDLE) & op_avail;

   // what gets emitted this cycle
   always_comb begin
      produce  = 1'b0;
      prod_val = cur;
      rotate   = 1'b0;
      if (go) begin
         unique case (state_ff)
            ST_PASS1, ST_PASS2: begin
               if (merge_top) begin
                  produce  = 1'b1;
                  prod_val = cfg.top;
               end else begin
                  rotate  = 1'b1;
                  produce = member;
               end
            end
            ST_TOPFIX: begin
               produce  = !top_done_ff;
               prod_val = cfg.top;
            end
            ST_ZERO: begin
               produce  = 1'b1;
               prod_val = '0;
            end
            ST_IDLE, ST_JUMP, ST_FLUSH: begin
               produce = 1'b0;
            end
            default: produce = 1'b0;
         endcase
      end
   end

   assign cost = (pos_ff >= prod_val) ? (pos_ff - prod_val) : (prod_val - pos_ff);
   assign sum  = {1'b0, acc_ff} + {{(TRAVEL_W - CYL_W + 1){1'b0}}, cost};
   assign jsum = {1'b0, acc_ff} + {{(TRAVEL_W - CYL_W + 1){1'b0}}, cfg.top};

   // insertion position compare, one per cell
   always_comb begin
      for (int i = 0; i < N; i++) begin
         gt[i] = !valid_ff[i] | (cell_ff[i] > op_in.cyl);
      end
   end

   // ring update: insert, rotate, or clear at end of run
   always_comb begin
      for (int i = 0; i < N; i++) begin
         cell_in[i]  = cell_ff[i];
         valid_in[i] = valid_ff[i];
      end
      if (op_pop && !op_in.run) begin
         for (int i = 0; i < N; i++) begin
            if (gt[i]) begin
               if (i == 0) begin
                  cell_in[i]  = op_in.cyl;
                  valid_in[i] = 1'b1;
               end else if (!gt[i-1]) begin
                  cell_in[i]  = op_in.cyl;
                  valid_in[i] = 1'b1;
               end else begin
                  cell_in[i]  = cell_ff[i-1];
                  valid_in[i] = valid_ff[i-1];
               end
            end
         end
      end else if (rotate) begin
         for (int i = 0; i < N; i++) begin
            if (up_ff) begin
               cell_in[i]  = cell_ff[(i + 1) % N];
               valid_in[i] = valid_ff[(i + 1) % N];
            end else begin
               cell_in[i]  = cell_ff[(i + N - 1) % N];
               valid_in[i] = valid_ff[(i + N - 1) % N];
            end
         end
      end else if (state_ff == ST_FLUSH && go) begin
         valid_in = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (op_pop && op_in.run) state_in = ST_PASS1;
         ST_PASS1:  if (pass_end) state_in = up_ff ? ST_TOPFIX : ST_ZERO;
         ST_TOPFIX: if (go) state_in = up_ff ? ST_JUMP : ST_FLUSH;
         ST_JUMP:   if (go) state_in = up_ff ? ST_ZERO : ST_PASS2;
         ST_ZERO:   if (go) state_in = up_ff ? ST_PASS2 : ST_JUMP;
         ST_PASS2:  if (pass_end) state_in = up_ff ? ST_FLUSH : ST_TOPFIX;
         ST_FLUSH:  if (go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and result register updates
   always_comb begin
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      top_done_in   = top_done_ff;
      ovf_in        = ovf_ff;
      up_in         = up_ff;
      hold_valid_in = hold_valid_ff;
      hold_cyl_in   = hold_cyl_ff;
      rsp_valid_in  = rsp_valid_ff & !rsp_ready;
      rsp_cyl_in    = rsp_cyl_ff;
      rsp_travel_in = rsp_travel_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (op_pop && op_in.run) begin
         cnt_in      = '0;
         pos_in      = cfg.head;
         acc_in      = '0;
         top_done_in = 1'b0;
         ovf_in      = op_in.ovf;
         up_in       = cfg.up;
      end
      if (rotate) begin
         cnt_in = (cnt_ff == CW'(N - 1)) ? '0 : cnt_ff + CW'(1);
      end
      if (produce) begin
         if (hold_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_cyl_in    = hold_cyl_ff;
            rsp_travel_in = '0;
            rsp_last_in   = 1'b0;
            rsp_ovf_in    = ovf_ff;
         end
         hold_valid_in = 1'b1;
         hold_cyl_in   = prod_val;
         acc_in        = sum[TRAVEL_W] ? '1 : sum[TRAVEL_W-1:0];
         pos_in        = prod_val;
         if (prod_val == cfg.top && (state_ff == ST_TOPFIX || merge_top)) begin
            top_done_in = 1'b1;
         end
      end
      // wrap jump between the two groups
      if (state_ff == ST_JUMP && go) begin
         acc_in = jsum[TRAVEL_W] ? '1 : jsum[TRAVEL_W-1:0];
         pos_in = up_ff ? '0 : cfg.top;
      end
      if (state_ff == ST_TOPFIX && go) begin
         top_done_in = 1'b1;
      end
      // last stop carries the total
      if (state_ff == ST_FLUSH && go) begin
         rsp_valid_in  = 1'b1;
         rsp_cyl_in    = hold_cyl_ff;
         rsp_travel_in = acc_ff;
         rsp_last_in   = 1'b1;
         rsp_ovf_in    = ovf_ff;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         top_done_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         top_done_ff   <= top_done_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      pos_ff        <= pos_in;
      acc_ff        <= acc_in;
      ovf_ff        <= ovf_in;
      up_ff         <= up_in;
      hold_cyl_ff   <= hold_cyl_in;
      rsp_cyl_ff    <= rsp_cyl_in;
      rsp_travel_ff <= rsp_travel_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cyl    = rsp_cyl_ff;
   assign rsp_travel = rsp_travel_ff;
   assign rsp_ovf    = rsp_ovf_ff;
   assign rsp_last   = rsp_last_ff;

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff) else $error("stop left in hold");
   a_top_served: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> top_done_ff && hold_valid_ff)
      else $error("top stop missing at end of run");
   a_idle_counter: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> cnt_ff == '0) else $error("pass counter not home");
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH && go |=> rsp_valid_ff && rsp_last_ff)
      else $error("final stop not marked last");

endmodule
`default_nettype wire

/* hdl/circular_scan_disk_scheduler.sv */
// Top level of the circular-scan disk scheduler: config registers and the three parts.
//
//  channel | dir | transfer when          | contents
//  req     | in  | req_tvalid&req_tready  | tuser: cmd; tdata: request_cylinder
//  rsp     | out | rsp_tvalid&rsp_tready  | tdata: served_cylinder, total_travel;
//          |     |                        | tuser: overflowed; tlast: is_last
//  csr     | in  | csr_we                 | csr_addr register index, csr_wdata value
//
// Requests may arrive back to back while the two-entry queue has room.
// A run, once popped from the queue, walks the ring in two passes with top, jump and zero
// steps between them and a flush step at the end; when sweeping down the top step follows the
// second pass. Stops found in a pass cost nothing extra; a top stop inside a pass is an extra step.
// Reset clears the ring valid bits, fill count and overflow flag.
// A stalled rsp side freezes the walk; the two-entry queue takes two commands meanwhile.
`default_nettype none
module circular_scan_disk_scheduler #(
   parameter int MAX_PENDING = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [15:0] request_cylinder
   input  wire         req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] served_cylinder, [33:16] total_travel, pad
   output logic        rsp_tuser,   // [0] overflowed
   output logic        rsp_tlast,
   input  wire         csr_we,
   input  wire  [1:0]  csr_addr,
   input  wire  [15:0] csr_wdata
);
   import csd_pkg::*;

   logic [CYL_W-1:0] top_ff, head_ff;
   logic             up_ff;
   cfg_type          cfg;
   op_type           f_op, q_op;
   logic             f_push, q_room, q_avail, q_pop;
   logic [15:0]      r_cyl;
   logic [17:0]      r_travel;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff  <= RESET_TOP;
         head_ff <= RESET_HEAD;
         up_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_TOP_CYLINDER: top_ff  <= csr_wdata;
            REG_START_HEAD:   head_ff <= csr_wdata;
            REG_SWEEP_UP:     up_ff   <= csr_wdata[0];
            default:          up_ff   <= up_ff;
         endcase
      end
   end

   assign cfg.top  = top_ff;
   assign cfg.head = head_ff;
   assign cfg.up   = up_ff;

   csd_front #(.MAX_PENDING(MAX_PENDING)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_cmd   (req_tuser),
      .in_cyl   (req_tdata),
      .in_ready (req_tready),
      .op_out   (f_op),
      .op_push  (f_push),
      .op_room  (q_room)
   );

   csd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (f_push),
      .push_op (f_op),
      .room    (q_room),
      .avail   (q_avail),
      .pop_op  (q_op),
      .pop     (q_pop)
   );

   csd_engine #(.MAX_PENDING(MAX_PENDING)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .op_avail   (q_avail),
      .op_in      (q_op),
      .op_pop     (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_cyl    (r_cyl),
      .rsp_travel (r_travel),
      .rsp_ovf    (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, r_travel, r_cyl};

endmodule
`default_nettype wire

/* tb/sv/tb_circular_scan_disk_scheduler.sv */
// Self-checking testbench of the circular-scan disk scheduler: random and directed streams.
`default_nettype none
module tb_circular_scan_disk_scheduler;
   import csd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 32;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [17:0] TRAVEL_SAT = 18'h3FFFF;

   typedef struct packed {
      logic             cmd;
      logic [CYL_W-1:0] cyl;
   } req_item_type;

   typedef struct packed {
      logic [CYL_W-1:0]    cyl;
      logic [TRAVEL_W-1:0] travel;
      logic                ovf;
      logic                last;
   } stop_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [39:0] rsp_tdata;
   wire         rsp_tuser;
   wire         rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   circular_scan_disk_scheduler #(.MAX_PENDING(DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [CYL_W-1:0] mdl_top = RESET_TOP;
   logic [CYL_W-1:0] mdl_head = RESET_HEAD;
   logic             mdl_up = 1'b1;
   logic [CYL_W-1:0] mdl_store[DEPTH];
   int               mdl_count = 0;
   logic             mdl_ovf = 1'b0;

   req_item_type pending_reqs[$];
   stop_type     expected_stops[$];
   int        idle_pct = 0;
   int        stall_pct = 0;
   int        hold_cycles = 0;
   int        errors = 0;
   int        cycles = 0;

   // ready as seen at the last rising edge, i.e. the transfer just happened
   logic req_tready_s = 1'b0;

   // sort helper
   function automatic void sort_asc(ref logic [CYL_W-1:0] a[$]);
      a.sort();
   endfunction

   // advance the predictor by one accepted request
   task automatic predict_request(input req_item_type it);
      logic [CYL_W-1:0] lo[$];
      logic [CYL_W-1:0] hi[$];
      logic [CYL_W-1:0] order[$];
      logic [CYL_W-1:0] pos;
      longint           travel;
      stop_type         s;
      if (it.cmd == CMD_ADD) begin
         if (mdl_count < DEPTH) begin
            mdl_store[mdl_count] = it.cyl;
            mdl_count++;
         end else
            mdl_ovf = 1'b1;
      end else begin
         lo.push_back('0);
         hi.push_back(mdl_top);
         for (int i = 0; i < mdl_count; i++)
            if (mdl_store[i] < mdl_head) lo.push_back(mdl_store[i]);
            else hi.push_back(mdl_store[i]);
         sort_asc(lo);
         sort_asc(hi);
         pos = mdl_head;
         travel = 0;
         if (mdl_up) begin
            foreach (hi[i]) begin
               travel += (pos > hi[i]) ? pos - hi[i] : hi[i] - pos;
               pos = hi[i];
               order.push_back(pos);
            end
            travel += mdl_top;
            pos = '0;
            foreach (lo[i]) begin
               travel += lo[i] - pos;
               pos = lo[i];
               order.push_back(pos);
            end
         end else begin
            for (int i = lo.size() - 1; i >= 0; i--) begin
               travel += (pos > lo[i]) ? pos - lo[i] : lo[i] - pos;
               pos = lo[i];
               order.push_back(pos);
            end
            travel += mdl_top;
            pos = mdl_top;
            for (int i = hi.size() - 1; i >= 0; i--) begin
               travel += (pos > hi[i]) ? pos - hi[i] : hi[i] - pos;
               pos = hi[i];
               order.push_back(pos);
            end
         end
         if (travel > TRAVEL_SAT) travel = TRAVEL_SAT;
         foreach (order[i]) begin
            s.cyl = order[i];
            s.last = (i == order.size() - 1);
            s.travel = s.last ? travel[17:0] : '0;
            s.ovf = mdl_ovf;
            expected_stops.push_back(s);
         end
         mdl_count = 0;
         mdl_ovf = 1'b0;
      end
   endtask

   // driver: offers queued requests, changes at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_s) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_reqs[0].cmd;
               req_tdata  <= pending_reqs[0].cyl;
               void'(pending_reqs.pop_front());
            end else
               req_tvalid <= 1'b0;
         end
         rsp_tready <= (hold_cycles == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor: transfers sampled at the rising edge
   always @(posedge clock) begin
      stop_type got;
      stop_type exp_s;
      cycles <= cycles + 1;
      req_tready_s <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_request('{cmd: req_tuser, cyl: req_tdata});
         if (rsp_tvalid && rsp_tready) begin
            got = '{cyl: rsp_tdata[15:0], travel: rsp_tdata[33:16],
                    ovf: rsp_tuser, last: rsp_tlast};
            if (expected_stops.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected stop %p", got);
            end else begin
               exp_s = expected_stops.pop_front();
               if (got !== exp_s) begin
                  errors++;
                  if (errors <= 10) $display("stop: expected %p, got %p", exp_s, got);
               end
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   task automatic add(input logic [15:0] c);
      pending_reqs.push_back('{cmd: CMD_ADD, cyl: c});
   endtask

   task automatic run_cmd(input logic [15:0] junk);
      pending_reqs.push_back('{cmd: CMD_RUN, cyl: junk});
   endtask

   // wait until everything queued is sent and answered, then idle out
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_stops.size() > 0)
         @(posedge clock);
      repeat (2 * DEPTH + 50) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_TOP_CYLINDER: mdl_top = v;
         REG_START_HEAD:   mdl_head = v;
         default:          mdl_up = v[0];
      endcase
   endtask

   // random batches: each is mostly adds ending in a run
   task automatic random_batch(input int n);
      int k;
      for (int b = 0; b < n; b++) begin
         k = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 4, DEPTH) : $urandom_range(8);
         for (int i = 0; i < k; i++)
            case ($urandom_range(3))
               0: add(16'($urandom()));
               1: add(16'(mdl_head + $urandom_range(2) - 1));
               default: add(16'($urandom_range(mdl_top + 2)));
            endcase
         run_cmd(16'($urandom()));
      end
   endtask

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("circular_scan_disk_scheduler: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset config, empty run, head-equal, extremes, above top
      run_cmd(16'hFFFF);
      add(16'd50); add(16'd0); add(16'hFFFF); add(16'd49); add(16'd199); add(16'd300);
      run_cmd(16'h0000);
      drain();
      write_reg(REG_SWEEP_UP, 16'h0000);
      add(16'd50); add(16'd10); add(16'd120); add(16'd0);
      run_cmd(16'h1234);
      drain();
      // extremes of the registers
      write_reg(REG_TOP_CYLINDER, 16'hFFFF);
      write_reg(REG_START_HEAD, 16'hFFFF);
      write_reg(REG_SWEEP_UP, 16'h0001);
      for (int i = 0; i < 12; i++) add(i[0] ? 16'hFFFF : 16'h0001);
      run_cmd(16'h0);
      drain();
      write_reg(REG_TOP_CYLINDER, 16'd1);
      write_reg(REG_START_HEAD, 16'd0);
      write_reg(REG_SWEEP_UP, 16'h0000);
      add(16'd0); add(16'd1); add(16'hAAAA); add(16'h5555);
      run_cmd(16'h0);
      drain();

      // random phases across idling mixes and settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         write_reg(REG_TOP_CYLINDER, (ph == 5) ? 16'hFFFF : 16'($urandom_range(1000, 1)));
         write_reg(REG_START_HEAD, (ph == 6) ? 16'h0000 : 16'($urandom_range(mdl_top + 5)));
         write_reg(REG_SWEEP_UP, {15'd0, ph[0]});
         if (ph == 4) hold_cycles = 400;
         random_batch(5);
         drain();
      end
      hold_cycles = 0;
      drain();

      if (errors == 0)
         $display("circular_scan_disk_scheduler: match");
      else
         $display("circular_scan_disk_scheduler: mismatch");
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
hdl/csd_pkg.sv
hdl/csd_front.sv
hdl/csd_queue.sv
hdl/csd_engine.sv
hdl/circular_scan_disk_scheduler.sv
tb/sv/tb_circular_scan_disk_scheduler.sv
